/* rtl/bplru_pkg.sv */
// Package for the buffer pool LRU frame map.
// Shared constants and the request type passed from the front queue to the back end.
package bplru_pkg;

  localparam int unsigned DefaultPoolFrames = 16;
  localparam int unsigned PageW = 32;
  localparam int unsigned FrameOutW = 4;
  localparam logic [PageW-1:0] ReservedPageId = '1;

  typedef enum logic {
    FUNC_FETCH = 1'b0,
    FUNC_NEW   = 1'b1
  } func_e;

  typedef struct packed {
    func_e            func;
    logic [PageW-1:0] page_number;
    logic             mark_dirty;
    logic             invalid;
  } req_t;

endpackage

/* rtl/bplru_if.sv */
// Valid/ready channel interfaces for requests and results.
// Depends on bplru_pkg.
interface bplru_req_if import bplru_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             func;
  logic [PageW-1:0] page_number;
  logic             mark_dirty;

  modport source (output valid, func, page_number, mark_dirty, input ready);
  modport sink   (input valid, func, page_number, mark_dirty, output ready);
endinterface

interface bplru_rsp_if import bplru_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [FrameOutW-1:0] frame;
  logic                 hit;
  logic                 read_from_disk;
  logic                 evicted_valid;
  logic [PageW-1:0]     evicted_page;
  logic                 write_back;

  modport source (output valid, frame, hit, read_from_disk, evicted_valid, evicted_page,
                  write_back, input ready);
  modport sink   (input valid, frame, hit, read_from_disk, evicted_valid, evicted_page,
                  write_back, output ready);
  modport monitor (input valid, ready, frame, hit, read_from_disk, evicted_valid,
                   evicted_page, write_back);
endinterface

/* rtl/bplru_front.sv */
// Front end: accepts requests, flags the reserved page id, holds them in a 2-entry queue.
// Depends on bplru_pkg and bplru_if.
module bplru_front import bplru_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  bplru_req_if.sink   in_if,
  output logic        req_valid_o,
  output req_t        req_o,
  input  logic        req_ready_i
);

  req_t       mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       push, pop;
  req_t       new_req;

  assign in_if.ready = (count_q != 2'd2);
  assign push        = in_if.valid && in_if.ready;
  assign req_valid_o = (count_q != 2'd0);
  assign pop         = req_valid_o && req_ready_i;
  assign req_o       = mem_q[rd_ptr_q];

  always_comb begin
    new_req.func        = func_e'(in_if.func);
    new_req.page_number = in_if.page_number;
    new_req.mark_dirty  = in_if.mark_dirty;
    new_req.invalid     = (in_if.page_number == ReservedPageId);
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= new_req;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

/* rtl/bplru_back.sv */
// Back end: frame tag compare, LRU rank update, fill/evict and the result register.
// Depends on bplru_pkg and bplru_if.
module bplru_back import bplru_pkg::*; #(
  parameter int unsigned PoolFrames = DefaultPoolFrames
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  input  req_t        req_i,
  output logic        req_ready_o,
  bplru_rsp_if.source out_if
);

  localparam int unsigned FrameW = $clog2(PoolFrames);
  localparam int unsigned FillW  = $clog2(PoolFrames + 1);
  localparam logic [FrameW-1:0] LastRank = FrameW'(PoolFrames - 1);
  localparam logic [FillW-1:0]  FillMax  = FillW'(PoolFrames);

  logic [PageW-1:0]  page_q [PoolFrames];
  logic [PoolFrames-1:0] valid_q, valid_d, dirty_q, dirty_d;
  logic [FrameW-1:0] rank_q [PoolFrames];
  logic [FrameW-1:0] rank_d [PoolFrames];
  logic [FillW-1:0]  fill_q, fill_d;

  logic                 out_valid_q;
  logic [FrameOutW-1:0] frame_q, frame_d;
  logic                 hit_q, hit_d, rd_q, rd_d, ev_q, ev_d, wb_q, wb_d;
  logic [PageW-1:0]     evp_q, evp_d;

  logic                      pop, work;
  logic                      hit, was_valid;
  logic [FrameW-1:0]         hit_idx, lru_idx, f;
  logic [FrameW-1:0]         old_rank;
  logic [FrameW+FrameOutW-1:0] f_wide;

  assign req_ready_o = !out_valid_q || out_if.ready;
  assign pop         = req_valid_i && req_ready_o;
  assign work        = pop && !req_i.invalid;

  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    lru_idx = '0;
    for (int i = 0; i < PoolFrames; i++) begin
      if (valid_q[i] && page_q[i] == req_i.page_number) begin
        hit     = 1'b1;
        hit_idx = hit_idx | FrameW'(i);
      end
      if (valid_q[i] && rank_q[i] == LastRank) begin
        lru_idx = lru_idx | FrameW'(i);
      end
    end

    ev_d = 1'b0;
    if (hit) begin
      f = hit_idx;
    end else if (fill_q < FillMax) begin
      f = fill_q[FrameW-1:0];
    end else begin
      f    = lru_idx;
      ev_d = 1'b1;
    end
    was_valid = valid_q[f];
    old_rank  = rank_q[f];

    valid_d = valid_q;
    dirty_d = dirty_q;
    fill_d  = fill_q;
    for (int i = 0; i < PoolFrames; i++) begin
      rank_d[i] = rank_q[i];
      if (FrameW'(i) == f) begin
        rank_d[i] = '0;
      end else if (valid_q[i] && (!was_valid || rank_q[i] < old_rank)) begin
        rank_d[i] = rank_q[i] + 1'b1;
      end
    end
    valid_d[f] = 1'b1;
    if (hit && req_i.func == FUNC_FETCH) begin
      dirty_d[f] = dirty_q[f] | req_i.mark_dirty;
    end else begin
      dirty_d[f] = req_i.mark_dirty;
    end
    if (!hit && fill_q < FillMax) begin
      fill_d = fill_q + 1'b1;
    end

    f_wide  = {{FrameOutW{1'b0}}, f};
    frame_d = f_wide[FrameOutW-1:0];
    hit_d   = hit;
    rd_d    = !hit && req_i.func == FUNC_FETCH;
    evp_d   = ev_d ? page_q[f] : '0;
    wb_d    = ev_d && dirty_q[f];
    if (req_i.invalid) begin
      frame_d = '0;
      hit_d   = 1'b0;
      rd_d    = 1'b0;
      ev_d    = 1'b0;
      evp_d   = '0;
      wb_d    = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (work && !hit) begin
      page_q[f] <= req_i.page_number;
    end
    if (pop) begin
      frame_q <= frame_d;
      hit_q   <= hit_d;
      rd_q    <= rd_d;
      ev_q    <= ev_d;
      evp_q   <= evp_d;
      wb_q    <= wb_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      dirty_q     <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < PoolFrames; i++) begin
        rank_q[i] <= '0;
      end
    end else begin
      if (work) begin
        valid_q <= valid_d;
        dirty_q <= dirty_d;
        fill_q  <= fill_d;
        rank_q  <= rank_d;
      end
      if (pop) begin
        out_valid_q <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_if.valid          = out_valid_q;
  assign out_if.frame          = frame_q;
  assign out_if.hit            = hit_q;
  assign out_if.read_from_disk = rd_q;
  assign out_if.evicted_valid  = ev_q;
  assign out_if.evicted_page   = evp_q;
  assign out_if.write_back     = wb_q;

endmodule

/* rtl/buffer_pool_lru_frame_map_core.sv */
// Buffer pool frame map with LRU replacement, top level.
// Path: each request is written into the queue register, then its result into the result
// register, from which the result transaction is offered on out_if.
// Throughput: one request per cycle; input stalls only when a held result fills the 2-entry queue.
// Reset (rst_ni, async low): queue empty, all frames invalid, ranks and fill count zero.
// Depends on bplru_pkg, bplru_if, bplru_front and bplru_back.
module buffer_pool_lru_frame_map_core import bplru_pkg::*; #(
  parameter int unsigned PoolFrames = DefaultPoolFrames
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  bplru_req_if.sink   in_if,
  bplru_rsp_if.source out_if
);

  logic req_valid, req_ready;
  req_t req;

  bplru_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_if       (in_if),
    .req_valid_o (req_valid),
    .req_o       (req),
    .req_ready_i (req_ready)
  );

  bplru_back #(
    .PoolFrames (PoolFrames)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid),
    .req_i       (req),
    .req_ready_o (req_ready),
    .out_if      (out_if)
  );

endmodule

/* rtl/bplru_checker.sv */
// Port-level assertions for the buffer pool frame map, bound to the top level.
// Depends on bplru_pkg and bplru_if.
module bplru_checker import bplru_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             valid_i,
  input logic             ready_i,
  input logic [FrameOutW-1:0] frame_i,
  input logic             hit_i,
  input logic             read_i,
  input logic             ev_valid_i,
  input logic [PageW-1:0] ev_page_i,
  input logic             wb_i
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && hit_i |-> !read_i && !ev_valid_i)
    else $error("hit result reports a miss action");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !ev_valid_i |-> ev_page_i == '0 && !wb_i)
    else $error("eviction fields set without an eviction");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && ev_valid_i |-> ev_page_i != ReservedPageId)
    else $error("evicted the reserved page id");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !ready_i |=> valid_i && $stable(frame_i) && $stable(ev_page_i))
    else $error("stalled result changed");

endmodule

bind buffer_pool_lru_frame_map_core bplru_checker u_bplru_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .valid_i    (out_if.valid),
  .ready_i    (out_if.ready),
  .frame_i    (out_if.frame),
  .hit_i      (out_if.hit),
  .read_i     (out_if.read_from_disk),
  .ev_valid_i (out_if.evicted_valid),
  .ev_page_i  (out_if.evicted_page),
  .wb_i       (out_if.write_back)
);
